// ===== design/suhp_pkg.sv =====
// ----------------------------------------------------------------------------
// suhp_pkg
// Shared types and codes for the SOCKS5 UDP request header parser.
// ----------------------------------------------------------------------------
package suhp_pkg;

  typedef enum logic [3:0] {
    FC_RSV  = 4'd0,
    FC_FRAG = 4'd1,
    FC_ATYP = 4'd2,
    FC_DLEN = 4'd3,
    FC_ADDR = 4'd4,
    FC_PHI  = 4'd5,
    FC_PLO  = 4'd6,
    FC_PAY  = 4'd7,
    FC_DISC = 4'd8
  } field_code_t;

  typedef enum logic [1:0] {
    V_OK    = 2'd0,
    V_SHORT = 2'd1,
    V_HDR   = 2'd2,
    V_ATYP  = 2'd3
  } verdict_t;

  localparam logic [7:0] ATYP_IPV4   = 8'h01;
  localparam logic [7:0] ATYP_DOMAIN = 8'h03;
  localparam logic [7:0] ATYP_IPV6   = 8'h04;

  localparam logic [8:0] IPV4_LEN = 9'd4;
  localparam logic [8:0] IPV6_LEN = 9'd16;
  localparam logic [8:0] HDR_FIXED = 9'd4;
  localparam logic [8:0] POS_MAX  = 9'd511;

  typedef struct packed {
    logic [7:0]  byte_out;
    field_code_t field_code;
    logic [7:0]  addr_index;
    logic        end_flag;
    verdict_t    verdict;
    logic [7:0]  addr_kind;
    logic [15:0] dest_port;
  } result_t;

endpackage

// ===== design/suhp_classify.sv =====
// ----------------------------------------------------------------------------
// suhp_classify
// Per-datagram parse state and byte classification for one step.
// ----------------------------------------------------------------------------
module suhp_classify import suhp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output result_t    result
);

  logic [8:0]  pos_r,  pos_nxt;
  logic [7:0]  atyp_r, atyp_nxt;
  logic [7:0]  dlen_r, dlen_nxt;
  logic [15:0] port_r, port_nxt;
  verdict_t    err_r,  err_nxt;
  logic        hdr_r,  hdr_nxt;

  logic [8:0]  off;
  logic [8:0]  aoff;
  logic [8:0]  alen;
  logic        ap;
  field_code_t field;
  logic [7:0]  idx;
  verdict_t    verdict;

  always_comb begin
    pos_nxt  = pos_r;
    atyp_nxt = atyp_r;
    dlen_nxt = dlen_r;
    port_nxt = port_r;
    err_nxt  = err_r;
    hdr_nxt  = hdr_r;
    field    = FC_DISC;
    idx      = 8'd0;
    ap       = 1'b0;
    off      = pos_r - HDR_FIXED;
    aoff     = off;
    alen     = IPV4_LEN;

    if (err_r != V_OK) begin
      field = FC_DISC;
    end else if (pos_r < 9'd2) begin
      field = FC_RSV;
      if (data_byte != 8'd0) err_nxt = V_HDR;
    end else if (pos_r == 9'd2) begin
      field = FC_FRAG;
      if (data_byte != 8'd0) err_nxt = V_HDR;
    end else if (pos_r == 9'd3) begin
      field    = FC_ATYP;
      atyp_nxt = data_byte;
      if (!(data_byte inside {ATYP_IPV4, ATYP_DOMAIN, ATYP_IPV6})) err_nxt = V_ATYP;
    end else if (hdr_r) begin
      field = FC_PAY;
    end else begin
      case (atyp_r)
        ATYP_IPV4: begin
          ap   = 1'b1;
          alen = IPV4_LEN;
        end
        ATYP_IPV6: begin
          ap   = 1'b1;
          alen = IPV6_LEN;
        end
        ATYP_DOMAIN: begin
          if (off == 9'd0) begin
            field    = FC_DLEN;
            dlen_nxt = data_byte;
          end else begin
            ap   = 1'b1;
            aoff = off - 9'd1;
            alen = {1'b0, dlen_r};
          end
        end
        default: field = FC_DISC;
      endcase
      if (ap) begin
        if (aoff < alen) begin
          field = FC_ADDR;
          idx   = aoff[7:0];
        end else if (aoff == alen) begin
          field    = FC_PHI;
          port_nxt = {data_byte, 8'h00};
        end else begin
          field    = FC_PLO;
          port_nxt = port_r | {8'h00, data_byte};
          hdr_nxt  = 1'b1;
        end
      end
    end

    if (pos_r != POS_MAX) pos_nxt = pos_r + 9'd1;

    if (pos_r < 9'd3)        verdict = V_SHORT;
    else if (err_nxt != V_OK) verdict = err_nxt;
    else if (!hdr_nxt)       verdict = V_SHORT;
    else                     verdict = V_OK;
  end

  always_comb begin
    result.byte_out   = data_byte;
    result.field_code = field;
    result.addr_index = idx;
    result.end_flag   = last_byte;
    result.verdict    = last_byte ? verdict : V_OK;
    result.addr_kind  = last_byte ? atyp_nxt : 8'd0;
    result.dest_port  = (last_byte && verdict == V_OK) ? port_nxt : 16'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && last_byte)) begin
      pos_r  <= '0;
      atyp_r <= '0;
      dlen_r <= '0;
      port_r <= '0;
      err_r  <= V_OK;
      hdr_r  <= 1'b0;
    end else if (step) begin
      pos_r  <= pos_nxt;
      atyp_r <= atyp_nxt;
      dlen_r <= dlen_nxt;
      port_r <= port_nxt;
      err_r  <= err_nxt;
      hdr_r  <= hdr_nxt;
    end
  end

endmodule

// ===== design/socks5_udp_header_parser_unit.sv =====
// ----------------------------------------------------------------------------
// socks5_udp_header_parser_unit
// Classifies each byte of a SOCKS5 UDP relay datagram and reports the header
// verdict, address type and destination port on the final byte.
//
//   channel | ports                                   | dir
//   input   | in_valid in_ready in_data_byte in_last_byte | in
//   result  | out_valid out_ready out_byte_out ...     | out
//
// One byte per cycle sustained while the result side is not stalled; each
// byte passes an input register and then a result register before its
// result word is presented. The parse state advances as a byte moves from
// the input to the result register and returns to its reset value after
// the final byte. Synchronous reset clears both valid flags and the parse
// state. A stalled result holds the result register and a full input
// register; the input side stays ready while either register has room.
// ----------------------------------------------------------------------------
module socks5_udp_header_parser_unit import suhp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte_out,
  output logic [3:0]  out_field_code,
  output logic [7:0]  out_addr_index,
  output logic        out_end_flag,
  output logic [1:0]  out_verdict,
  output logic [7:0]  out_addr_kind,
  output logic [15:0] out_dest_port
);

  logic       s1_valid_r;
  logic [7:0] s1_data_r;
  logic       s1_last_r;
  logic       out_valid_r;
  result_t    res;
  result_t    out_r;
  logic       s1_move;

  assign s1_move  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_move;

  suhp_classify u_classify (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s1_move),
    .data_byte (s1_data_r),
    .last_byte (s1_last_r),
    .result    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) s1_valid_r <= in_valid;
      if (s1_move) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data_byte;
      s1_last_r <= in_last_byte;
    end
    if (s1_move) out_r <= res;
  end

  assign out_valid      = out_valid_r;
  assign out_byte_out   = out_r.byte_out;
  assign out_field_code = out_r.field_code;
  assign out_addr_index = out_r.addr_index;
  assign out_end_flag   = out_r.end_flag;
  assign out_verdict    = out_r.verdict;
  assign out_addr_kind  = out_r.addr_kind;
  assign out_dest_port  = out_r.dest_port;

  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && out_valid_r && !out_ready))
    else $error("input stalled with room in the pipeline");

  a_mid_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_end_flag) |->
      (out_verdict == V_OK && out_addr_kind == 8'd0 && out_dest_port == 16'd0))
    else $error("verdict fields set on a non-final byte");

  a_idx_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_field_code != FC_ADDR) |-> out_addr_index == 8'd0)
    else $error("address index outside the address field");

  a_port_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_verdict != V_OK) |-> out_dest_port == 16'd0)
    else $error("port reported on a rejected datagram");

endmodule

// ===== dv/suhp_header_tracker.sv =====
// ----------------------------------------------------------------------------
// suhp_header_tracker
// Watches both channels of the SOCKS5 UDP header parser, computes the
// classification and verdict for every accepted byte, and compares each
// result word field by field against the oldest pending prediction.
// ----------------------------------------------------------------------------
module suhp_header_tracker
  import suhp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_byte_out,
  input  logic [3:0]  out_field_code,
  input  logic [7:0]  out_addr_index,
  input  logic        out_end_flag,
  input  logic [1:0]  out_verdict,
  input  logic [7:0]  out_addr_kind,
  input  logic [15:0] out_dest_port,
  output int          field_errors,
  output int          awaited_results
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [8:0]  pos_q;
  logic [7:0]  atyp_q;
  logic [7:0]  dlen_q;
  logic [15:0] port_q;
  verdict_t    err_q;
  logic        hdr_done_q;

  result_t predicted_fields[$];

  function automatic void clear_parse();
    pos_q      = '0;
    atyp_q     = '0;
    dlen_q     = '0;
    port_q     = '0;
    err_q      = V_OK;
    hdr_done_q = 1'b0;
  endfunction

  function automatic field_code_t place_addr_port(input logic [8:0] off,
                                                  input logic [8:0] span,
                                                  input logic [7:0] b,
                                                  output logic [7:0] idx);
    idx = 8'd0;
    if (off < span) begin
      idx = off[7:0];
      return FC_ADDR;
    end
    if (off == span) begin
      port_q = {b, 8'h00};
      return FC_PHI;
    end
    port_q     = port_q | {8'h00, b};
    hdr_done_q = 1'b1;
    return FC_PLO;
  endfunction

  function automatic result_t classify_next_byte(input logic [7:0] b, input logic last);
    result_t     r;
    field_code_t fc;
    logic [7:0]  idx;
    logic [8:0]  off;
    verdict_t    v;
    fc  = FC_DISC;
    idx = 8'd0;
    v   = V_OK;
    off = pos_q - HDR_FIXED;
    if (err_q != V_OK) begin
      fc = FC_DISC;
    end else if (pos_q < 9'd2) begin
      fc = FC_RSV;
      if (b != 8'h00) err_q = V_HDR;
    end else if (pos_q == 9'd2) begin
      fc = FC_FRAG;
      if (b != 8'h00) err_q = V_HDR;
    end else if (pos_q == 9'd3) begin
      fc     = FC_ATYP;
      atyp_q = b;
      if (b != ATYP_IPV4 && b != ATYP_DOMAIN && b != ATYP_IPV6) err_q = V_ATYP;
    end else if (hdr_done_q) begin
      fc = FC_PAY;
    end else if (atyp_q == ATYP_IPV4) begin
      fc = place_addr_port(off, IPV4_LEN, b, idx);
    end else if (atyp_q == ATYP_IPV6) begin
      fc = place_addr_port(off, IPV6_LEN, b, idx);
    end else if (atyp_q == ATYP_DOMAIN) begin
      if (off == 9'd0) begin
        fc     = FC_DLEN;
        dlen_q = b;
      end else begin
        fc = place_addr_port(off - 9'd1, {1'b0, dlen_q}, b, idx);
      end
    end

    if (pos_q < POS_MAX) pos_q = pos_q + 9'd1;

    r.byte_out   = b;
    r.field_code = fc;
    r.addr_index = idx;
    r.end_flag   = last;
    r.verdict    = V_OK;
    r.addr_kind  = 8'h00;
    r.dest_port  = 16'h0000;
    if (last) begin
      if (pos_q < HDR_FIXED)  v = V_SHORT;
      else if (err_q != V_OK) v = err_q;
      else if (!hdr_done_q)   v = V_SHORT;
      r.verdict   = v;
      r.addr_kind = atyp_q;
      r.dest_port = (v == V_OK) ? port_q : 16'h0000;
      clear_parse();
    end
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      field_errors++;
    end
  endfunction

  always @(posedge clk) begin : watch
    result_t want;
    if (!rst_n) begin
      clear_parse();
      predicted_fields.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_fields.size() == 0) begin
          $display("%0t: result word with none expected, actual byte %0h", $time,
                   out_byte_out);
          field_errors++;
        end else begin
          want = predicted_fields.pop_front();
          check_field("byte_out",   16'(want.byte_out),   16'(out_byte_out));
          check_field("field_code", 16'(want.field_code), 16'(out_field_code));
          check_field("addr_index", 16'(want.addr_index), 16'(out_addr_index));
          check_field("end_flag",   16'(want.end_flag),   16'(out_end_flag));
          check_field("verdict",    16'(want.verdict),    16'(out_verdict));
          check_field("addr_kind",  16'(want.addr_kind),  16'(out_addr_kind));
          check_field("dest_port",  want.dest_port,       out_dest_port);
        end
      end
      if (in_valid && in_ready)
        predicted_fields.push_back(classify_next_byte(in_data_byte, in_last_byte));
    end
    awaited_results = predicted_fields.size();
  end

endmodule

// ===== dv/socks5_udp_header_parser_unit_tb.sv =====
// ----------------------------------------------------------------------------
// socks5_udp_header_parser_unit_tb
// Feeds SOCKS5 UDP relay datagrams byte by byte into the header parser:
// directed header cases first, then mostly well-formed random datagrams with
// truncated, malformed and noise ones mixed in, under random stalls on both
// channels. The header tracker predicts and checks every result word.
// ----------------------------------------------------------------------------
module socks5_udp_header_parser_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import suhp_pkg::*;

  localparam int ITEM_TARGET  = 1700;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int LONG_HOLD    = 80;
  localparam int DRAIN_CYCLES = 10;

  typedef logic [7:0] byte_q_t[$];

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_data_byte;
  logic        in_last_byte;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_byte_out;
  logic [3:0]  out_field_code;
  logic [7:0]  out_addr_index;
  logic        out_end_flag;
  logic [1:0]  out_verdict;
  logic [7:0]  out_addr_kind;
  logic [15:0] out_dest_port;

  int      field_errors;
  int      awaited_results;
  int      bytes_sent;
  int      cycle_count;
  bit      long_hold_req;
  bit      steady_flow;
  bit      sender_gapless;
  byte_q_t dgram_bytes;

  socks5_udp_header_parser_unit uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data_byte   (in_data_byte),
    .in_last_byte   (in_last_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte_out   (out_byte_out),
    .out_field_code (out_field_code),
    .out_addr_index (out_addr_index),
    .out_end_flag   (out_end_flag),
    .out_verdict    (out_verdict),
    .out_addr_kind  (out_addr_kind),
    .out_dest_port  (out_dest_port)
  );

  suhp_header_tracker tracker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_last_byte    (in_last_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte_out    (out_byte_out),
    .out_field_code  (out_field_code),
    .out_addr_index  (out_addr_index),
    .out_end_flag    (out_end_flag),
    .out_verdict     (out_verdict),
    .out_addr_kind   (out_addr_kind),
    .out_dest_port   (out_dest_port),
    .field_errors    (field_errors),
    .awaited_results (awaited_results)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin : result_sink
    int   run_len;
    logic level;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (long_hold_req) begin
        level         = 1'b0;
        run_len       = LONG_HOLD;
        long_hold_req = 1'b0;
      end else if (steady_flow) begin
        level   = 1'b1;
        run_len = 1;
      end else if ($urandom_range(0, 9) < 7) begin
        level   = 1'b1;
        run_len = $urandom_range(1, 8);
      end else begin
        level   = 1'b0;
        run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
      end
      out_ready <= level;
      repeat (run_len) @(negedge clk);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic idle_sender();
    int gap;
    gap = 0;
    if (!sender_gapless) begin
      case ($urandom_range(0, 9))
        0, 1, 2:  gap = $urandom_range(1, 3);
        3:        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 25) : 0;
        default:  gap = 0;
      endcase
    end
    if (gap > 0) begin
      in_valid     <= 1'b0;
      in_data_byte <= 8'($urandom);
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_datagram(input byte_q_t d);
    foreach (d[i]) begin
      send_byte(d[i], i == d.size() - 1);
      idle_sender();
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (awaited_results != 0);
  endtask

  task automatic build_random_datagram();
    int         kind;
    int         span;
    int         pay_len;
    int         cut;
    logic [7:0] atyp;
    dgram_bytes.delete();
    kind = $urandom_range(0, 99);
    if (kind < 75) begin
      dgram_bytes = '{8'h00, 8'h00, 8'h00};
      case ($urandom_range(0, 2))
        0:       atyp = ATYP_IPV4;
        1:       atyp = ATYP_DOMAIN;
        default: atyp = ATYP_IPV6;
      endcase
      dgram_bytes.push_back(atyp);
      if (atyp == ATYP_DOMAIN) begin
        span = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 12);
        dgram_bytes.push_back(8'(span));
      end else begin
        span = (atyp == ATYP_IPV4) ? 4 : 16;
      end
      pay_len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 6);
      repeat (span + 2 + pay_len) dgram_bytes.push_back(8'($urandom));
      if (kind >= 63) begin
        cut = $urandom_range(1, dgram_bytes.size() - 1);
        while (dgram_bytes.size() > cut) void'(dgram_bytes.pop_back());
      end
    end else if (kind < 85) begin
      repeat ($urandom_range(1, 10)) dgram_bytes.push_back(8'($urandom));
      for (int i = 0; i < 3 && i < dgram_bytes.size(); i++) dgram_bytes[i] = 8'h00;
      cut = $urandom_range(0, 2);
      if (cut < dgram_bytes.size()) dgram_bytes[cut] = 8'($urandom_range(1, 255));
    end else if (kind < 93) begin
      do atyp = 8'($urandom);
      while (atyp == ATYP_IPV4 || atyp == ATYP_DOMAIN || atyp == ATYP_IPV6);
      dgram_bytes = '{8'h00, 8'h00, 8'h00, atyp};
      repeat ($urandom_range(0, 6)) dgram_bytes.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(1, 8))
        dgram_bytes.push_back(($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom));
    end
  endtask

  initial begin : stimulus
    in_valid       = 1'b0;
    in_data_byte   = 8'h00;
    in_last_byte   = 1'b0;
    rst_n          = 1'b0;
    long_hold_req  = 1'b0;
    steady_flow    = 1'b0;
    sender_gapless = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_datagram('{8'hff});
    send_datagram('{8'h00, 8'h00, 8'h00, ATYP_IPV4, 8'hc0, 8'ha8, 8'h00, 8'hff,
                    8'h01, 8'hbb, 8'h7e});
    send_datagram('{8'h00, 8'h00, 8'h00, ATYP_DOMAIN, 8'h00, 8'hff, 8'hff});
    send_datagram('{8'h00, 8'h80, 8'h00, ATYP_IPV4});
    send_datagram('{8'h00, 8'h00, 8'h01});
    send_datagram('{8'h00, 8'h00, 8'h00, 8'h02, 8'h55});
    drain_results();

    long_hold_req  = 1'b1;
    sender_gapless = 1'b1;
    repeat (4) begin
      build_random_datagram();
      send_datagram(dgram_bytes);
    end
    steady_flow = 1'b1;
    repeat (8) begin
      build_random_datagram();
      send_datagram(dgram_bytes);
    end
    steady_flow    = 1'b0;
    sender_gapless = 1'b0;
    drain_results();

    dgram_bytes = '{8'h00, 8'h00, 8'h00, ATYP_IPV4};
    repeat (4 + 2 + 520) dgram_bytes.push_back(8'($urandom));
    send_datagram(dgram_bytes);

    while (bytes_sent < ITEM_TARGET) begin
      build_random_datagram();
      send_datagram(dgram_bytes);
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (field_errors == 0 && awaited_results == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== socks5_udp_header_parser_unit.f =====
design/suhp_pkg.sv
design/suhp_classify.sv
design/socks5_udp_header_parser_unit.sv
dv/suhp_header_tracker.sv
dv/socks5_udp_header_parser_unit_tb.sv
